// File: sv/m4cft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4cft_pkg
// Shared constants and binary32 helper functions for the column transform.
// ----------------------------------------------------------------------------
package m4cft_pkg;

  localparam int unsigned NumCfg   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned ItemW    = 128;
  localparam int unsigned MulLat   = 3;
  localparam int unsigned AddLat   = 4;
  localparam int unsigned TotalLat = MulLat + 3 * AddLat;

  localparam logic [31:0] Qnan    = 32'h7FC0_0000;
  localparam logic [30:0] InfBits = 31'h7F80_0000;

  typedef logic signed [9:0] fexp_t;

  // Leading zero count; zero input returns 0 (never used that way).
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Round to nearest even. v holds 24 kept bits, a guard bit and a sticky bit,
  // MSB set; e is the biased exponent of that MSB.
  function automatic logic [31:0] round_pack(input logic sign, input fexp_t e,
                                             input logic [25:0] v);
    logic [51:0] t;
    logic [25:0] w;
    logic [4:0]  amt;
    logic [30:0] base;
    logic [23:0] keep;
    logic        up;
    t    = '0;
    w    = v;
    amt  = '0;
    base = '0;
    keep = '0;
    up   = 1'b0;
    if (e >= fexp_t'(255)) begin
      return {sign, InfBits};
    end
    if (e <= fexp_t'(0)) begin
      if (fexp_t'(1) - e > fexp_t'(26)) amt = 5'd26;
      else amt = 5'(fexp_t'(1) - e);
      t    = {v, 26'b0} >> amt;
      w    = {t[51:27], t[26] | (|t[25:0])};
      base = '0;
    end else begin
      base = 31'(e - fexp_t'(1)) << 23;
    end
    keep = w[25:2];
    up   = w[1] & (w[0] | keep[0]);
    return {sign, base + 31'(keep) + 31'(up)};
  endfunction

endpackage

// File: sv/m4cft_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4cft_fmul
// Three-stage binary32 multiplier: multiply, normalize, round.
// ----------------------------------------------------------------------------
module m4cft_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import m4cft_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        sp_c;
  logic [31:0] spv_c;

  logic        s1_sp, s2_sp;
  logic [31:0] s1_spv, s2_spv;
  logic        s1_sign, s2_sign;
  fexp_t       s1_e, s2_e;
  logic [47:0] s1_p;
  logic [25:0] s2_v;
  logic [5:0]  lz;
  logic [47:0] norm;

  always_comb begin
    sgn    = a[31] ^ b[31];
    a_nan  = a[30:0] > InfBits;
    b_nan  = b[30:0] > InfBits;
    a_inf  = a[30:0] == InfBits;
    b_inf  = b[30:0] == InfBits;
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    sp_c   = 1'b1;
    spv_c  = {sgn, 31'b0};
    if (a_nan || b_nan) spv_c = Qnan;
    else if (a_inf || b_inf) spv_c = (a_zero || b_zero) ? Qnan : {sgn, InfBits};
    else if (a_zero || b_zero) spv_c = {sgn, 31'b0};
    else sp_c = 1'b0;
  end

  always_comb begin
    lz   = lzc48(s1_p);
    norm = s1_p << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sp   <= sp_c;
      s1_spv  <= spv_c;
      s1_sign <= sgn;
      s1_e    <= fexp_t'({2'b0, ea}) + fexp_t'({2'b0, eb}) - fexp_t'(126);
      s1_p    <= 48'(ma) * 48'(mb);
      s2_sp   <= s1_sp;
      s2_spv  <= s1_spv;
      s2_sign <= s1_sign;
      s2_e    <= s1_e - fexp_t'({4'b0, lz});
      s2_v    <= {norm[47:23], |norm[22:0]};
      y       <= s2_sp ? s2_spv : round_pack(s2_sign, s2_e, s2_v);
    end
  end

endmodule

// File: sv/m4cft_fadd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4cft_fadd
// Four-stage binary32 adder: order, align and add, normalize, round.
// ----------------------------------------------------------------------------
module m4cft_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import m4cft_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [31:0] x, z;
  logic [7:0]  ex, ez;
  logic        sp_c;
  logic [31:0] spv_c;

  logic        s1_sp, s2_sp, s3_sp;
  logic [31:0] s1_spv, s2_spv, s3_spv;
  logic        s1_sign, s2_sign, s3_sign;
  logic        s1_sub;
  logic [7:0]  s1_e, s1_d, s2_e;
  logic [23:0] s1_mx, s1_mz;
  logic [27:0] s2_r;
  fexp_t       s3_e;
  logic [25:0] s3_v;

  logic [53:0] t;
  logic [26:0] bal, am;
  logic [4:0]  amt;
  logic [27:0] r;
  logic [5:0]  lz;
  logic [27:0] norm;

  always_comb begin
    a_nan  = a[30:0] > InfBits;
    b_nan  = b[30:0] > InfBits;
    a_inf  = a[30:0] == InfBits;
    b_inf  = b[30:0] == InfBits;
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    sp_c   = 1'b1;
    spv_c  = a;
    if (a_nan || b_nan) spv_c = Qnan;
    else if (a_inf) spv_c = (b_inf && (a[31] != b[31])) ? Qnan : a;
    else if (b_inf) spv_c = b;
    else if (a_zero && b_zero) spv_c = {a[31] & b[31], 31'b0};
    else if (a_zero) spv_c = b;
    else if (b_zero) spv_c = a;
    else sp_c = 1'b0;
    // order by magnitude
    if (b[30:0] > a[30:0]) begin
      x = b;
      z = a;
    end else begin
      x = a;
      z = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ez = (z[30:23] == 8'd0) ? 8'd1 : z[30:23];
  end

  always_comb begin
    amt = (s1_d > 8'd27) ? 5'd27 : s1_d[4:0];
    t   = {s1_mz, 3'b0, 27'b0} >> amt;
    bal = {t[53:28], t[27] | (|t[26:0])};
    am  = {s1_mx, 3'b0};
    r   = s1_sub ? ({1'b0, am} - {1'b0, bal}) : ({1'b0, am} + {1'b0, bal});
  end

  always_comb begin
    lz   = lzc48({s2_r, 20'b0});
    norm = s2_r << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sp   <= sp_c;
      s1_spv  <= spv_c;
      s1_sign <= x[31];
      s1_sub  <= x[31] ^ z[31];
      s1_e    <= ex;
      s1_d    <= ex - ez;
      s1_mx   <= {x[30:23] != 8'd0, x[22:0]};
      s1_mz   <= {z[30:23] != 8'd0, z[22:0]};
      // exact cancellation gives +0
      s2_sp   <= s1_sp | (s1_sub && r == '0);
      s2_spv  <= s1_sp ? s1_spv : 32'd0;
      s2_sign <= s1_sign;
      s2_e    <= s1_e;
      s2_r    <= r;
      s3_sp   <= s2_sp;
      s3_spv  <= s2_spv;
      s3_sign <= s2_sign;
      s3_e    <= fexp_t'({2'b0, s2_e}) + fexp_t'(1) - fexp_t'({4'b0, lz});
      s3_v    <= {norm[27:3], |norm[2:0]};
      y       <= s3_sp ? s3_spv : round_pack(s3_sign, s3_e, s3_v);
    end
  end

endmodule

// File: sv/mat4_column_transform_fp32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_column_transform_fp32
// One column of a 4x4 binary32 matrix product per transaction.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  s_*       in   right column: elem0..elem3, 32 bits each
//  m_*       out  product column: row0..row3, 32 bits each
//  apb       cfg  eight 64-bit left-matrix registers at 8*i
//
//  Products pass from the multipliers through a chain of three adders.
//  One transaction enters every cycle unless m_tready stalls the output; the 16
//  multipliers and 12 adders each take a new operand pair per cycle.
//  Reset clears the valid bits and the matrix registers (all zero).
//  A stall on m_tready freezes every stage together; nothing is dropped.
// ----------------------------------------------------------------------------
module mat4_column_transform_fp32 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // elem0 [31:0], elem1 [63:32], elem2 [95:64], elem3 [127:96]
  input  logic [m4cft_pkg::ItemW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // row0 [31:0], row1 [63:32], row2 [95:64], row3 [127:96]
  output logic [m4cft_pkg::ItemW-1:0]   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [m4cft_pkg::AddrW-1:0]   paddr,
  input  logic [m4cft_pkg::CfgW-1:0]    pwdata,
  output logic [m4cft_pkg::CfgW-1:0]    prdata,
  output logic                          pready
);
  import m4cft_pkg::*;

  logic [CfgW-1:0]     cfg [NumCfg];
  logic [TotalLat-1:0] vld;
  logic                en;

  logic [31:0] prod  [4][4];
  logic [31:0] sum01 [4];
  logic [31:0] sum2  [4];
  logic [31:0] sum3  [4];

  // Every stage advances unless the output holds a result nobody takes.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TotalLat-1];
  assign pready   = 1'b1;
  assign prdata   = cfg[paddr[AddrW-1:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCfg; i++) cfg[i] <= '0;
    end else if (psel && penable && pwrite) begin
      cfg[paddr[AddrW-1:3]] <= pwdata;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TotalLat-2:0], s_tvalid};
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic [31:0] p2_dly [AddLat];
    logic [31:0] p3_dly [2*AddLat];

    for (genvar c = 0; c < 4; c++) begin : g_col
      m4cft_fmul u_mul (
        .clk (clk),
        .en  (en),
        .a   (cfg[c*2 + r/2][(r%2)*32 +: 32]),
        .b   (s_tdata[c*32 +: 32]),
        .y   (prod[r][c])
      );
    end

    // Hold later products until the running sum catches up.
    always_ff @(posedge clk) begin
      if (en) begin
        p2_dly[0] <= prod[r][2];
        for (int k = 1; k < AddLat; k++) p2_dly[k] <= p2_dly[k-1];
        p3_dly[0] <= prod[r][3];
        for (int k = 1; k < 2*AddLat; k++) p3_dly[k] <= p3_dly[k-1];
      end
    end

    m4cft_fadd u_add01 (
      .clk (clk), .en (en), .a (prod[r][0]), .b (prod[r][1]), .y (sum01[r])
    );
    m4cft_fadd u_add2 (
      .clk (clk), .en (en), .a (sum01[r]), .b (p2_dly[AddLat-1]), .y (sum2[r])
    );
    m4cft_fadd u_add3 (
      .clk (clk), .en (en), .a (sum2[r]), .b (p3_dly[2*AddLat-1]), .y (sum3[r])
    );

    assign m_tdata[r*32 +: 32] = sum3[r];
  end

  a_ready_follows_output: assert property (@(posedge clk)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_entry_valid: assert property (@(posedge clk) disable iff (rst)
    (en && !rst) |=> vld[0] == $past(s_tvalid))
    else $error("accepted transaction lost at pipeline entry");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (!en && !rst) |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule
